>>> sv/rflm_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the RF level median / peak hold block:
// default sizes, register codes and reset values, state types, config and status structs.
// No dependencies.
package rflm_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int LEVEL_BITS   = 16;
    localparam int TIME_BITS    = 32;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_OFFSET = 3'd3;

    localparam logic [CFG_BITS-1:0]          HOLD_TIME_RST = 16'd500;
    localparam logic [CFG_BITS-1:0]          DECAY_RST     = 16'd51;
    localparam logic [CFG_BITS-1:0]          GAIN_RST      = 16'd11745;
    localparam logic signed [CFG_BITS-1:0]   OFFSET_RST    = -16'sd24320;
    localparam logic signed [LEVEL_BITS-1:0] PEAK_RST      = -16'sd20480;

    typedef struct packed {
        logic [CFG_BITS-1:0]        hold_time_ms;
        logic [CFG_BITS-1:0]        decay_per_ms;
        logic [CFG_BITS-1:0]        count_gain;
        logic signed [CFG_BITS-1:0] level_offset;
    } rflm_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rflm_med_stat_t;

    typedef enum logic [2:0] {
        MED_IDLE,
        MED_WRITE,
        MED_READ,
        MED_DRAIN,
        MED_DONE
    } med_state_t;

    typedef enum logic [2:0] {
        PK_IDLE,
        PK_MUL,
        PK_LEVEL,
        PK_UPDATE,
        PK_OUT
    } pk_state_t;

endpackage

>>> sv/rflm_median.sv
`timescale 1ns / 1ps
// Sample window memory and upper-median selection by streaming insertion sort.
// Depends on rflm_pkg.
module rflm_median
    import rflm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] sample,
    output rflm_med_stat_t         stat,
    output logic [SAMPLE_BITS-1:0] median
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);

    med_state_t state_reg, state_next;

    logic [PW-1:0] wpos_reg, wpos_next;
    logic          filled_reg, filled_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0] ins_cnt_reg, ins_cnt_next;
    logic          rd_vld_reg, rd_vld_next;

    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0] sorted_reg [WINDOW];
    logic [SAMPLE_BITS-1:0] sorted_next [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] window_mem [WINDOW];

    logic          mem_we;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [CW-1:0] half_cnt;
    logic [PW-1:0] half_idx;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MED_IDLE:  if (start) state_next = MED_WRITE;
            MED_WRITE: state_next = MED_READ;
            MED_READ:  if (rd_cnt_reg == cnt_reg - CW'(1)) state_next = MED_DRAIN;
            MED_DRAIN: state_next = MED_DONE;
            MED_DONE:  state_next = MED_IDLE;
            default:   state_next = MED_IDLE;
        endcase
    end

    // state decoded outputs
    always_comb
    begin
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        stat.busy = 1'b1;
        stat.done = 1'b0;
        unique case (state_reg)
            MED_IDLE:  stat.busy = 1'b0;
            MED_WRITE: mem_we = 1'b1;
            MED_READ:  rd_en = 1'b1;
            MED_DRAIN: ;
            MED_DONE:  stat.done = 1'b1;
            default:   stat.busy = 1'b0;
        endcase
    end

    // window pointer, entry count and read sequencing
    always_comb
    begin
        wpos_next    = wpos_reg;
        filled_next  = filled_reg;
        cnt_next     = cnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        ins_cnt_next = ins_cnt_reg;
        sample_next  = sample_reg;
        rd_vld_next  = rd_en;
        if (start && state_reg == MED_IDLE)
        begin
            sample_next = sample;
        end
        if (mem_we)
        begin
            if (wpos_reg == LAST_POS)
            begin
                wpos_next   = '0;
                filled_next = 1'b1;
                cnt_next    = FULL_CNT;
            end
            else
            begin
                wpos_next = wpos_reg + PW'(1);
                cnt_next  = filled_reg ? FULL_CNT : CW'(wpos_reg) + CW'(1);
            end
            rd_cnt_next  = '0;
            ins_cnt_next = '0;
        end
        if (rd_en)
        begin
            rd_cnt_next = rd_cnt_reg + CW'(1);
        end
        if (rd_vld_reg)
        begin
            ins_cnt_next = ins_cnt_reg + CW'(1);
        end
    end

    // insert the word just read into the ascending list; equal keys go after
    always_comb
    begin
        logic [WINDOW-1:0] gt;
        for (int k = 0; k < WINDOW; k++)
        begin
            gt[k] = (CW'(k) < ins_cnt_reg) && (sorted_reg[k] > rd_data_reg);
        end
        sorted_next = sorted_reg;
        if (rd_vld_reg)
        begin
            if (gt[0] || ins_cnt_reg == '0)
            begin
                sorted_next[0] = rd_data_reg;
            end
            for (int k = 1; k < WINDOW; k++)
            begin
                if (gt[k-1])
                begin
                    sorted_next[k] = sorted_reg[k-1];
                end
                else if (gt[k] || ins_cnt_reg == CW'(k))
                begin
                    sorted_next[k] = rd_data_reg;
                end
            end
        end
    end

    assign rd_addr  = rd_cnt_reg[PW-1:0];
    assign half_cnt = cnt_reg >> 1;
    assign half_idx = half_cnt[PW-1:0];
    assign median   = sorted_reg[half_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= MED_IDLE;
            wpos_reg    <= '0;
            filled_reg  <= 1'b0;
            cnt_reg     <= '0;
            rd_cnt_reg  <= '0;
            ins_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            filled_reg  <= filled_next;
            cnt_reg     <= cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            ins_cnt_reg <= ins_cnt_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        sorted_reg <= sorted_next;
    end

    // window memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[wpos_reg] <= sample_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= window_mem[rd_addr];
        end
    end

    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= LAST_POS)
        else $error("window write pointer out of range");

    a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MED_READ) |->
        (cnt_reg != '0 && cnt_reg <= FULL_CNT && rd_cnt_reg < cnt_reg))
        else $error("window read beyond valid entries");

    a_all_inserted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MED_DONE) |-> (ins_cnt_reg == cnt_reg && !rd_vld_reg))
        else $error("median taken before all entries were sorted");

endmodule

>>> sv/rflm_peak_hold.sv
`timescale 1ns / 1ps
// Level mapping (gain, offset, saturation), peak hold with decay, output register.
// Depends on rflm_pkg.
module rflm_peak_hold
    import rflm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SAMPLE_BITS-1:0]        median,
    input  logic [TIME_BITS-1:0]          now,
    input  rflm_cfg_t                     cfg,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SAMPLE_BITS-1:0]        median_sample,
    output logic signed [LEVEL_BITS-1:0]  level_dbm,
    output logic signed [LEVEL_BITS-1:0]  peak_hold_dbm
);

    localparam int GW = SAMPLE_BITS + CFG_BITS;      // gain product
    localparam int SW = GW - 6;                      // scaled sum with sign and carry
    localparam int DW = TIME_BITS + CFG_BITS;        // decay product
    localparam int PW = DW + 2;                      // decayed peak, signed
    localparam logic signed [SW-1:0] LVL_MAX = SW'(32767);
    localparam logic signed [SW-1:0] LVL_MIN = SW'(-32768);

    pk_state_t state_reg, state_next;

    logic [TIME_BITS-1:0]         prev_time_reg, prev_time_next;
    logic [TIME_BITS-1:0]         peak_time_reg, peak_time_next;
    logic signed [LEVEL_BITS-1:0] peak_level_reg, peak_level_next;
    logic                         out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]       med_reg, med_next;
    logic [GW-1:0]                gprod_reg, gprod_next;
    logic signed [LEVEL_BITS-1:0] level_reg, level_next;
    logic [TIME_BITS-1:0]         elapsed_reg, elapsed_next;
    logic [DW-1:0]                dprod_reg, dprod_next;
    logic                         expired_reg, expired_next;
    logic [SAMPLE_BITS-1:0]       out_med_reg, out_med_next;
    logic signed [LEVEL_BITS-1:0] out_level_reg, out_level_next;
    logic signed [LEVEL_BITS-1:0] out_peak_reg, out_peak_next;

    logic                         out_free;
    logic                         load;
    logic signed [SW-1:0]         lvl_sum;
    logic signed [PW-1:0]         decayed;
    logic [TIME_BITS-1:0]         held;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PK_IDLE:   if (start) state_next = PK_MUL;
            PK_MUL:    state_next = PK_LEVEL;
            PK_LEVEL:  state_next = PK_UPDATE;
            PK_UPDATE: state_next = PK_OUT;
            PK_OUT:    if (out_free) state_next = PK_IDLE;
            default:   state_next = PK_IDLE;
        endcase
    end

    // state decoded outputs
    always_comb
    begin
        busy = 1'b1;
        load = 1'b0;
        unique case (state_reg)
            PK_IDLE:   busy = 1'b0;
            PK_MUL:    ;
            PK_LEVEL:  ;
            PK_UPDATE: ;
            PK_OUT:    load = out_free;
            default:   busy = 1'b0;
        endcase
    end

    assign lvl_sum = $signed({2'b00, gprod_reg[GW-1:8]}) + SW'(cfg.level_offset);
    assign decayed = PW'(peak_level_reg) - $signed({2'b00, dprod_reg});
    assign held    = now - peak_time_reg;

    always_comb
    begin
        prev_time_next  = prev_time_reg;
        peak_time_next  = peak_time_reg;
        peak_level_next = peak_level_reg;
        med_next        = med_reg;
        gprod_next      = gprod_reg;
        level_next      = level_reg;
        elapsed_next    = elapsed_reg;
        dprod_next      = dprod_reg;
        expired_next    = expired_reg;
        out_med_next    = out_med_reg;
        out_level_next  = out_level_reg;
        out_peak_next   = out_peak_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (start && state_reg == PK_IDLE)
        begin
            med_next = median;
        end

        if (state_reg == PK_MUL)
        begin
            gprod_next     = med_reg * cfg.count_gain;
            elapsed_next   = now - prev_time_reg;
            prev_time_next = now;
        end

        if (state_reg == PK_LEVEL)
        begin
            if (lvl_sum > LVL_MAX)
            begin
                level_next = LVL_MAX[LEVEL_BITS-1:0];
            end
            else if (lvl_sum < LVL_MIN)
            begin
                level_next = LVL_MIN[LEVEL_BITS-1:0];
            end
            else
            begin
                level_next = lvl_sum[LEVEL_BITS-1:0];
            end
            dprod_next   = elapsed_reg * cfg.decay_per_ms;
            expired_next = held > TIME_BITS'(cfg.hold_time_ms);
        end

        if (state_reg == PK_UPDATE)
        begin
            if (level_reg > peak_level_reg)
            begin
                peak_level_next = level_reg;
                peak_time_next  = now;
            end
            else if (expired_reg)
            begin
                // decay floors at the current level
                if (decayed < PW'(level_reg))
                begin
                    peak_level_next = level_reg;
                end
                else
                begin
                    peak_level_next = decayed[LEVEL_BITS-1:0];
                end
            end
        end

        if (load)
        begin
            out_med_next   = med_reg;
            out_level_next = level_reg;
            out_peak_next  = peak_level_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PK_IDLE;
            prev_time_reg  <= '0;
            peak_time_reg  <= '0;
            peak_level_reg <= PEAK_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_time_reg  <= prev_time_next;
            peak_time_reg  <= peak_time_next;
            peak_level_reg <= peak_level_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg       <= med_next;
        gprod_reg     <= gprod_next;
        level_reg     <= level_next;
        elapsed_reg   <= elapsed_next;
        dprod_reg     <= dprod_next;
        expired_reg   <= expired_next;
        out_med_reg   <= out_med_next;
        out_level_reg <= out_level_next;
        out_peak_reg  <= out_peak_next;
    end

    assign out_valid     = out_valid_reg;
    assign median_sample = out_med_reg;
    assign level_dbm     = out_level_reg;
    assign peak_hold_dbm = out_peak_reg;

    a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PK_OUT) |-> (peak_level_reg >= level_reg))
        else $error("peak fell below current level");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == PK_IDLE))
        else $error("median delivered while peak stage busy");

    a_load_peak: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && out_peak_reg == $past(peak_level_reg)))
        else $error("output register missed the updated peak");

endmodule

>>> sv/rf_level_median_peak_hold_unit.sv
`timescale 1ns / 1ps
// RF detector level filter: windowed median, dBm mapping, peak hold with decay.
// Depends on rflm_pkg, rflm_median, rflm_peak_hold.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one ADC sample and its ms timestamp
//   per transaction. Output channel (out_valid / out_stall) returns the window
//   median, the mapped level and the peak hold value, one transaction per input.
//   Write registers via cfg_wr_en / cfg_index / cfg_data only while idle (the block
//   does not check): 0 hold time, 1 decay per ms, 2 counts-to-dB gain, 3 level offset.
// Sequence:
//   With n valid window entries (n = 5 once the window is full) the median stage
//   reads and sorts all n entries before the peak stage starts, and a new input is
//   taken only once both stages are idle. The window memory delivers one entry per
//   cycle for the median sort; gain and decay multiplies follow in their own cycles.
// Stall:
//   A finished result waits in the output register; the next input is taken
//   meanwhile, and its result is held back until the output register empties.
// Reset:
//   Clears the window fill state, timestamps and registers to defaults; the
//   peak starts at -80 dBm. Window contents are not cleared.
module rf_level_median_peak_hold_unit
    import rflm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        adc_sample,
    input  logic [TIME_BITS-1:0]          time_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SAMPLE_BITS-1:0]        median_sample,
    output logic signed [LEVEL_BITS-1:0]  level_dbm,
    output logic signed [LEVEL_BITS-1:0]  peak_hold_dbm,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data
);

    rflm_cfg_t            cfg_reg, cfg_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    rflm_med_stat_t         med_stat;
    logic [SAMPLE_BITS-1:0] med_value;
    logic                   pk_busy;
    logic                   accept;

    assign in_stall = med_stat.busy || pk_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_HOLD_TIME:    cfg_next.hold_time_ms = cfg_data;
                CFG_DECAY:        cfg_next.decay_per_ms = cfg_data;
                CFG_GAIN:         cfg_next.count_gain   = cfg_data;
                CFG_LEVEL_OFFSET: cfg_next.level_offset = $signed(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    assign now_next = accept ? time_ms : now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms <= HOLD_TIME_RST;
            cfg_reg.decay_per_ms <= DECAY_RST;
            cfg_reg.count_gain   <= GAIN_RST;
            cfg_reg.level_offset <= OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // timestamp stays put until the transaction has been fully processed
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
    end

    rflm_median #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (adc_sample),
        .stat   (med_stat),
        .median (med_value)
    );

    rflm_peak_hold #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_peak (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (med_stat.done),
        .median        (med_value),
        .now           (now_reg),
        .cfg           (cfg_reg),
        .busy          (pk_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median_sample (median_sample),
        .level_dbm     (level_dbm),
        .peak_hold_dbm (peak_hold_dbm)
    );

    a_one_stage_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(med_stat.busy && pk_busy))
        else $error("median and peak stages busy at once");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (med_stat.busy && now_reg == $past(time_ms)))
        else $error("accepted transaction not started");

    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        med_stat.done |=> (pk_busy && !med_stat.busy))
        else $error("median result not handed to peak stage");

endmodule

>>> tb/sv/rflm_level_checker.sv
`timescale 1ns / 1ps
// Scoreboard for rf_level_median_peak_hold_unit: mirrors the window median,
// dBm mapping and peak hold with decay, and checks each result transaction in order.
// Depends on rflm_pkg.
module rflm_level_checker
    import rflm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [SAMPLE_BITS_DEF-1:0]   adc_sample,
    input  logic [TIME_BITS-1:0]         time_ms,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [SAMPLE_BITS_DEF-1:0]   median_sample,
    input  logic signed [LEVEL_BITS-1:0] level_dbm,
    input  logic signed [LEVEL_BITS-1:0] peak_hold_dbm,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    output int                           fail_count,
    output int                           outstanding
);

    typedef struct {
        logic [SAMPLE_BITS_DEF-1:0]   median;
        logic signed [LEVEL_BITS-1:0] level;
        logic signed [LEVEL_BITS-1:0] peak;
    } level_result_t;

    rflm_cfg_t                  regs;
    logic [SAMPLE_BITS_DEF-1:0] window [WINDOW_DEF];
    int                         wr_pos;
    logic                       filled;
    logic [TIME_BITS-1:0]       last_time;
    int                         peak_lvl;
    logic [TIME_BITS-1:0]       peak_at;
    level_result_t              pending_levels [$];
    int                         n_fail;

    // one sample into the window, then median, level and peak hold update
    task automatic advance_peak_hold(input logic [SAMPLE_BITS_DEF-1:0] smp,
                                     input logic [TIME_BITS-1:0] now,
                                     output level_result_t res);
        logic [TIME_BITS-1:0]       elapsed;
        logic [TIME_BITS-1:0]       held;
        logic [SAMPLE_BITS_DEF-1:0] sorted [WINDOW_DEF];
        logic [SAMPLE_BITS_DEF-1:0] key;
        logic [SAMPLE_BITS_DEF-1:0] med;
        int                         count;
        int                         j;
        bit                         shifting;
        longint                     lvl;
        longint                     p;

        elapsed   = now - last_time;
        last_time = now;

        window[wr_pos] = smp;
        wr_pos++;
        if (wr_pos == WINDOW_DEF)
        begin
            wr_pos = 0;
            filled = 1'b1;
        end
        count = filled ? WINDOW_DEF : wr_pos;

        // insertion sort over the written entries only
        for (int i = 0; i < count; i++)
        begin
            key      = window[i];
            j        = i;
            shifting = 1'b1;
            while (shifting)
            begin
                if (j > 0)
                begin
                    if (sorted[j-1] > key)
                    begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    else
                        shifting = 1'b0;
                end
                else
                    shifting = 1'b0;
            end
            sorted[j] = key;
        end
        med = sorted[count / 2];   // upper middle for an even count

        lvl = ((longint'(med) * longint'(regs.count_gain)) >> 8)
              + longint'($signed(regs.level_offset));
        if (lvl > 32767)
            lvl = 32767;
        else if (lvl < -32768)
            lvl = -32768;

        if (lvl > peak_lvl)
        begin
            peak_lvl = int'(lvl);
            peak_at  = now;
        end
        else
        begin
            held = now - peak_at;
            if (held > TIME_BITS'(regs.hold_time_ms))
            begin
                // full-width product: never wraps, floor is the current level
                p = longint'(peak_lvl) - longint'(elapsed) * longint'(regs.decay_per_ms);
                if (p < lvl)
                    p = lvl;
                peak_lvl = int'(p);
            end
        end

        res.median = med;
        res.level  = LEVEL_BITS'(lvl);
        res.peak   = LEVEL_BITS'(peak_lvl);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        level_result_t want;
        if (!rst_n)
        begin
            regs.hold_time_ms = HOLD_TIME_RST;
            regs.decay_per_ms = DECAY_RST;
            regs.count_gain   = GAIN_RST;
            regs.level_offset = OFFSET_RST;
            wr_pos    = 0;
            filled    = 1'b0;
            last_time = '0;
            peak_lvl  = PEAK_RST;
            peak_at   = '0;
            pending_levels.delete();
        end
        else
        begin
            // results first: a transaction taken at this edge cannot be answered yet
            if (out_valid && !out_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    $error("unexpected result transaction: median %0d level %0d peak %0d",
                           median_sample, level_dbm, peak_hold_dbm);
                    n_fail++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (median_sample !== want.median)
                    begin
                        $error("median_sample: expected %0d, actual %0d",
                               want.median, median_sample);
                        n_fail++;
                    end
                    if (level_dbm !== want.level)
                    begin
                        $error("level_dbm: expected %0d, actual %0d", want.level, level_dbm);
                        n_fail++;
                    end
                    if (peak_hold_dbm !== want.peak)
                    begin
                        $error("peak_hold_dbm: expected %0d, actual %0d",
                               want.peak, peak_hold_dbm);
                        n_fail++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_HOLD_TIME:    regs.hold_time_ms = cfg_data;
                    CFG_DECAY:        regs.decay_per_ms = cfg_data;
                    CFG_GAIN:         regs.count_gain   = cfg_data;
                    CFG_LEVEL_OFFSET: regs.level_offset = cfg_data;
                    default:          ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                advance_peak_hold(adc_sample, time_ms, want);
                pending_levels.push_back(want);
            end
        end
        outstanding <= pending_levels.size();
        fail_count  <= n_fail;
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for rf_level_median_peak_hold_unit: clock, reset, stimulus
// with random idling on both channels, register phases and the verdict.
// Depends on rflm_pkg, rf_level_median_peak_hold_unit and rflm_level_checker.
module tb
    import rflm_pkg::*;
();

    localparam int HALF_PERIOD   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic [SAMPLE_BITS_DEF-1:0]   adc_sample = '0;
    logic [TIME_BITS-1:0]         time_ms    = '0;
    logic                         out_stall  = 1'b0;
    logic                         cfg_wr_en  = 1'b0;
    logic [CFG_IDX_BITS-1:0]      cfg_index  = CFG_HOLD_TIME;
    logic [CFG_BITS-1:0]          cfg_data   = '0;
    logic                         in_stall;
    logic                         out_valid;
    logic [SAMPLE_BITS_DEF-1:0]   median_sample;
    logic signed [LEVEL_BITS-1:0] level_dbm;
    logic signed [LEVEL_BITS-1:0] peak_hold_dbm;
    int                           fail_count;
    int                           outstanding;

    bit                           no_idle = 1'b0;
    logic [TIME_BITS-1:0]         stamp   = '0;

    rf_level_median_peak_hold_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_sample    (adc_sample),
        .time_ms       (time_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median_sample (median_sample),
        .level_dbm     (level_dbm),
        .peak_hold_dbm (peak_hold_dbm),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rflm_level_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_sample    (adc_sample),
        .time_ms       (time_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median_sample (median_sample),
        .level_dbm     (level_dbm),
        .peak_hold_dbm (peak_hold_dbm),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // mostly short idle runs, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] smp,
                               input logic [TIME_BITS-1:0] t);
        int gap;
        in_valid   <= 1'b1;
        adc_sample <= smp;
        time_ms    <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the input until every transaction sent has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_BITS-1:0] hold,
                                 input logic [CFG_BITS-1:0] decay,
                                 input logic [CFG_BITS-1:0] gain,
                                 input logic [CFG_BITS-1:0] offset);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HOLD_TIME;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_index <= CFG_DECAY;
        cfg_data  <= decay;
        @(posedge clk);
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= CFG_LEVEL_OFFSET;
        cfg_data  <= offset;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver stall runs
    initial
    begin
        int n;
        forever
        begin
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int                         r;
        int                         base;
        logic [SAMPLE_BITS_DEF-1:0] smp;

        base = 512;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window fills one entry at a time; even counts take the upper middle
        send_sample(10'd300, 32'd0);
        send_sample(10'd100, 32'd20);
        send_sample(10'd200, 32'd25);
        send_sample(10'd50, 32'd40);
        send_sample(10'd1023, 32'd41);
        send_sample(10'd1023, 32'd42);
        send_sample(10'd1023, 32'd43);   // median reaches full scale, peak rises
        send_sample(10'd0, 32'd100);
        send_sample(10'd0, 32'd101);
        send_sample(10'd0, 32'd102);
        send_sample(10'd0, 32'd543);     // held exactly the hold time: no decay yet
        send_sample(10'd0, 32'd544);     // one ms past it
        send_sample(10'd0, 32'hFFFF_FFFF);
        send_sample(10'd0, 32'd3);       // timestamp wraps

        // level clips high, then the full-width decay product drives peak to the floor
        drain_results();
        load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_sample(10'd1023, 32'd4);
        send_sample(10'd1023, 32'd5);
        send_sample(10'd1023, 32'd6);
        drain_results();
        load_settings(16'd0, 16'hFFFF, 16'd0, 16'h8000);
        send_sample(10'd0, 32'd7);
        send_sample(10'd512, 32'h8000_0007);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: load_settings(HOLD_TIME_RST, DECAY_RST, GAIN_RST, OFFSET_RST);
                1: load_settings(16'd0, 16'd1, 16'($urandom), 16'($urandom));
                2: load_settings(16'hFFFF, 16'hFFFF, GAIN_RST, OFFSET_RST);
                3: load_settings(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
                                 16'hFFFF, 16'h8000);
                4: load_settings(16'($urandom_range(0, 1000)), 16'd0, 16'd0, 16'h7FFF);
                default: load_settings(16'($urandom_range(0, 1000)),
                                       16'($urandom_range(0, 600)),
                                       16'($urandom), 16'($urandom));
            endcase
            no_idle = (ph == 2);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();

                r = $urandom_range(0, 99);
                if (r < 70)
                    stamp = stamp + $urandom_range(0, 40);
                else if (r < 85)
                    stamp = stamp + $urandom_range(41, 3000);
                else if (r < 93)
                    stamp = stamp + $urandom_range(3001, 70000);
                else if (r < 97)
                    stamp = $urandom;
                else
                    stamp = stamp - $urandom_range(1, 100);

                // slow drift with jumps, so peaks build up and then decay
                r = $urandom_range(0, 99);
                if (r < 6)
                    base = $urandom_range(0, 1023);
                else
                    base += int'($urandom_range(0, 60)) - 30;
                if (base < 0)
                    base = 0;
                else if (base > 1023)
                    base = 1023;

                if (r >= 90)
                    smp = SAMPLE_BITS_DEF'($urandom);
                else if (r >= 86)
                    smp = (r[0]) ? 10'd1023 : 10'd0;
                else
                    smp = SAMPLE_BITS_DEF'(base);
                send_sample(smp, stamp);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
